### rtl/core/rpn_stack_evaluator_macros.svh
// assertion macros for the rpn stack evaluator
// clocked on clock, disabled while reset is high; empty when SYNTHESIS is set
`ifndef RPN_STACK_EVALUATOR_MACROS_SVH
`define RPN_STACK_EVALUATOR_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every edge outside reset
`define RPN_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition must never be seen outside reset
`define RPN_ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`else

`define RPN_ASSERT(name, prop, msg)
`define RPN_ASSERT_NEVER(name, cond, msg)

`endif

`endif

### rtl/core/rpn_pkg.sv
// shared constants for the rpn stack evaluator: widths, stack size,
// operator and status codes; no dependencies
package rpn_pkg;

   localparam int DATA_W      = 32;
   localparam int STACK_DEPTH = 16;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int DEPTH_W     = 5;
   localparam int OP_W        = 2;
   localparam int STAT_W      = 2;
   localparam int ITER_W      = $clog2(DATA_W);
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;

   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_SUB = 2'd1;
   localparam logic [OP_W-1:0] OP_MUL = 2'd2;
   localparam logic [OP_W-1:0] OP_DIV = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_FEW  = 2'd1;
   localparam logic [STAT_W-1:0] ST_DIV0 = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

   localparam logic MODE_NUM = 1'b0;
   localparam logic MODE_OP  = 1'b1;

endpackage

### rtl/core/rpn_stack_evaluator.sv
// rpn stack evaluator: 16-entry operand stack with one shared add/subtract
// unit driving add, subtract, shift-add multiply and restoring divide
// depends on rpn_pkg and rpn_stack_evaluator_macros.svh
//
// usage: each req beat is one token. req_tuser is the mode (0 number,
// 1 operator); req_tdata carries the number and the operator code. every
// token gives exactly one rsp beat with the top of stack, the depth and a
// status (ok, too few operands, divide by zero, stack full).
// a number token, an operator with too few operands and a push onto a full
// stack give their rsp beat in the cycle after the req beat; add, subtract
// and divide by zero pass through an operand load state and a write-back
// state; multiply and divide read the left operand from the stack, make one
// pass of the shared adder per operand bit, then write the result back.
// only one token is in flight; req_tready is high while the sequencer is
// idle and the result register is empty or being drained in that cycle.
// a stalled rsp beat holds and blocks the next req beat.
// reset empties the stack (depth 0, top reads 0) and drops any result.
`include "rpn_stack_evaluator_macros.svh"

module rpn_stack_evaluator
   import rpn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // number[31:0], op[33:32], zero fill
   input  logic                  req_tuser,  // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // top_value[31:0], depth[36:32],
                                             // status[38:37], zero fill
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOAD = 2'd1;
   localparam logic [1:0] S_ITER = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [DATA_W-1:0]     top_ff, top_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [DATA_W-1:0]     right_ff, right_in;
   logic [DATA_W-1:0]     rem_ff, rem_in;
   logic [DATA_W-1:0]     quo_ff, quo_in;
   logic [DATA_W-1:0]     dvs_ff, dvs_in;
   logic                  neg_ff, neg_in;
   logic [DATA_W-1:0]     res_ff, res_in;
   logic [STAT_W-1:0]     stat_ff, stat_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic [DATA_W-1:0]     rd_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [DATA_W-1:0]     stack_mem [STACK_DEPTH];
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [DATA_W-1:0]     mem_wdata;
   logic [ADDR_W-1:0]     mem_raddr;

   logic [DATA_W:0]       alu_a, alu_b;
   logic                  alu_sub;
   logic [DATA_W+1:0]     alu_sum;

   logic                  req_beat;
   logic                  rsp_load;
   logic                  iter_last;
   logic                  no_borrow;
   logic [COUNT_W-1:0]    below_top;
   logic [DATA_W-1:0]     left_abs, right_abs, final_res;
   logic [STAT_W-1:0]     out_stat;
   logic [COUNT_W-1:0]    out_count;
   logic [DATA_W-1:0]     out_top;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign below_top = count_ff - COUNT_W'(2);
   assign mem_raddr = below_top[ADDR_W-1:0];
   assign iter_last = (iter_ff == ITER_W'(DATA_W - 1));
   assign left_abs  = rd_data_ff[DATA_W-1] ? (~rd_data_ff + DATA_W'(1)) : rd_data_ff;
   assign right_abs = right_ff[DATA_W-1] ? (~right_ff + DATA_W'(1)) : right_ff;

   // shared adder: operand pair per phase
   always_comb begin
      alu_a   = {1'b0, rd_data_ff};
      alu_b   = {1'b0, right_ff};
      alu_sub = (op_ff == OP_SUB);
      if (state_ff == S_ITER) begin
         if (op_ff == OP_DIV) begin
            alu_a   = {rem_ff, quo_ff[DATA_W-1]};
            alu_b   = {1'b0, dvs_ff};
            alu_sub = 1'b1;
         end else begin
            alu_a   = {1'b0, rem_ff};
            alu_b   = {1'b0, dvs_ff};
            alu_sub = 1'b0;
         end
      end
   end

   assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b ^ {(DATA_W + 1){alu_sub}}}
                      + (DATA_W + 2)'(alu_sub);
   assign no_borrow = alu_sum[DATA_W+1];

   always_comb begin
      final_res = res_ff;
      if (stat_ff == ST_OK) begin
         if (op_ff == OP_MUL) begin
            final_res = rem_ff;
         end else if (op_ff == OP_DIV) begin
            final_res = neg_ff ? (~quo_ff + DATA_W'(1)) : quo_ff;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      top_in    = top_ff;
      op_in     = op_ff;
      right_in  = right_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      res_in    = res_ff;
      stat_in   = stat_ff;
      iter_in   = iter_ff;
      mem_we    = 1'b0;
      mem_waddr = count_ff[ADDR_W-1:0];
      mem_wdata = req_tdata[DATA_W-1:0];
      rsp_load  = 1'b0;
      out_stat  = ST_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               op_in    = req_tdata[DATA_W+OP_W-1:DATA_W];
               right_in = top_ff;
               stat_in  = ST_OK;
               if (req_tuser == MODE_NUM) begin
                  rsp_load = 1'b1;
                  if (count_ff == COUNT_W'(STACK_DEPTH)) begin
                     out_stat = ST_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     top_in   = req_tdata[DATA_W-1:0];
                     count_in = count_ff + COUNT_W'(1);
                  end
               end else if (count_ff < COUNT_W'(2)) begin
                  // missing operand reads as zero and is pushed
                  rsp_load  = 1'b1;
                  out_stat  = ST_FEW;
                  mem_we    = 1'b1;
                  mem_wdata = '0;
                  top_in    = '0;
                  count_in  = count_ff + COUNT_W'(1);
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            iter_in = '0;
            priority if (op_ff == OP_ADD || op_ff == OP_SUB) begin
               res_in   = alu_sum[DATA_W-1:0];
               state_in = S_DONE;
            end else if (op_ff == OP_MUL) begin
               rem_in   = '0;
               quo_in   = right_ff;
               dvs_in   = rd_data_ff;
               state_in = S_ITER;
            end else if (right_ff == '0) begin
               res_in   = '0;
               stat_in  = ST_DIV0;
               state_in = S_DONE;
            end else begin
               rem_in   = '0;
               quo_in   = left_abs;
               dvs_in   = right_abs;
               neg_in   = rd_data_ff[DATA_W-1] ^ right_ff[DATA_W-1];
               state_in = S_ITER;
            end
         end
         S_ITER: begin
            iter_in = iter_ff + ITER_W'(1);
            if (op_ff == OP_DIV) begin
               rem_in = no_borrow ? alu_sum[DATA_W-1:0]
                                  : {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
               quo_in = {quo_ff[DATA_W-2:0], no_borrow};
            end else begin
               // shift-add, multiplier bits taken lsb first
               rem_in = quo_ff[0] ? alu_sum[DATA_W-1:0] : rem_ff;
               quo_in = quo_ff >> 1;
               dvs_in = dvs_ff << 1;
            end
            if (iter_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // two popped, one pushed at the lower slot
            mem_we    = 1'b1;
            mem_waddr = below_top[ADDR_W-1:0];
            mem_wdata = final_res;
            top_in    = final_res;
            count_in  = count_ff - COUNT_W'(1);
            out_stat  = stat_ff;
            rsp_load  = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_count   = count_in;
   assign out_top     = (count_in == '0) ? '0 : top_in;
   assign rsp_data_in = {{(RSP_DATA_W - DATA_W - DEPTH_W - STAT_W){1'b0}},
                         out_stat, DEPTH_W'(out_count), out_top};
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      right_ff <= right_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      neg_ff   <= neg_in;
      res_ff   <= res_in;
      stat_ff  <= stat_in;
      iter_ff  <= iter_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // operand stack: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= stack_mem[mem_raddr];
   end

   `RPN_ASSERT_NEVER(a_count_bound, (count_ff > COUNT_W'(STACK_DEPTH)), "stack count over depth")

   `RPN_ASSERT(a_op_start, ((req_beat && req_tuser == MODE_OP && count_ff >= COUNT_W'(2)) |=> (state_ff == S_LOAD)), "operator with two operands did not start")

   `RPN_ASSERT(a_iter_step, ((state_ff == S_ITER && !iter_last) |=> (state_ff == S_ITER && iter_ff == $past(iter_ff) + ITER_W'(1))), "iteration counter skipped")

   `RPN_ASSERT_NEVER(a_div0_src, (stat_ff == ST_DIV0 && state_ff == S_DONE && op_ff != OP_DIV), "divide by zero status from non-divide")

endmodule
